// ----- rtl/bps_pkg.sv -----
// shared types and constants of the battery power supervisor
package bps_pkg;

   localparam int LEVEL_W  = 8;
   localparam int TICKS_W  = 16;
   localparam int FUNC_W   = 2;
   localparam int CMD_W    = 8;
   localparam int LED_W    = 2;
   localparam int STREAK_W = 4;
   localparam int EMERG_W  = 6;
   localparam int CNT_W    = 2;
   localparam int NBYTES   = 3;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int REG_W    = 3;

   // transaction kinds
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CMD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   // led codes
   localparam logic [LED_W-1:0] LED_OFF    = 2'd0;
   localparam logic [LED_W-1:0] LED_GREEN  = 2'd1;
   localparam logic [LED_W-1:0] LED_YELLOW = 2'd2;
   localparam logic [LED_W-1:0] LED_RED    = 2'd3;

   // bus command bytes
   localparam logic [CMD_W-1:0] SEL_NONE     = 8'h00;
   localparam logic [CMD_W-1:0] SEL_LEVEL    = 8'h01;
   localparam logic [CMD_W-1:0] SEL_FLAG     = 8'h02;
   localparam logic [CMD_W-1:0] CMD_ARM      = 8'h03;
   localparam logic [CMD_W-1:0] CMD_DISARM   = 8'h04;
   localparam logic [CMD_W-1:0] SEL_ALL      = 8'h10;
   localparam logic [CMD_W-1:0] SEL_STARTUP  = 8'h11;
   localparam logic [CMD_W-1:0] SEL_SHUTDOWN = 8'h12;
   localparam logic [CMD_W-1:0] SEL_EMERG    = 8'h13;

   // configuration register indexes
   localparam logic [REG_W-1:0] REG_STARTUP   = 3'd0;
   localparam logic [REG_W-1:0] REG_SHUTDOWN  = 3'd1;
   localparam logic [REG_W-1:0] REG_EMERG     = 3'd2;
   localparam logic [REG_W-1:0] REG_WD_LIMIT  = 3'd3;
   localparam logic [REG_W-1:0] REG_BOOT_WAIT = 3'd4;

   // register reset values
   localparam logic [LEVEL_W-1:0] RST_STARTUP   = 8'd210;
   localparam logic [LEVEL_W-1:0] RST_SHUTDOWN  = 8'd208;
   localparam logic [LEVEL_W-1:0] RST_EMERG     = 8'd196;
   localparam logic [TICKS_W-1:0] RST_WD_LIMIT  = 16'd3000;
   localparam logic [TICKS_W-1:0] RST_BOOT_WAIT = 16'd600;

   localparam logic [TICKS_W-1:0]         WD_MAX     = 16'hFFFF;
   localparam logic [EMERG_W-1:0]         EMERG_MAX  = 6'd63;
   localparam logic signed [STREAK_W-1:0] STREAK_MAX = 4'sd7;
   localparam logic signed [STREAK_W-1:0] STREAK_MIN = -4'sd8;

   typedef struct packed {
      logic [LEVEL_W-1:0] startup_level;
      logic [LEVEL_W-1:0] shutdown_level;
      logic [LEVEL_W-1:0] emergency_level;
      logic [TICKS_W-1:0] watchdog_limit_ticks;
      logic [TICKS_W-1:0] boot_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [LEVEL_W-1:0] level_sample;
      logic               host_running;
      logic [CMD_W-1:0]   command_byte;
   } item_type;

   // all results caused by one input transaction
   typedef struct packed {
      logic [CNT_W-1:0]               count;
      logic [NBYTES-1:0][LEVEL_W-1:0] data;
      logic                           power_enable;
      logic                           shutdown_request;
      logic [LED_W-1:0]               led_code;
   } bundle_type;

endpackage

// ----- rtl/bps_ifs.sv -----
// request and response channel interfaces
interface bps_req_if;
   logic                         valid;
   logic                         ready;
   logic [bps_pkg::FUNC_W-1:0]   func;
   logic [bps_pkg::LEVEL_W-1:0]  level_sample;
   logic                         host_running;
   logic [bps_pkg::CMD_W-1:0]    command_byte;

   modport source (output valid, func, level_sample, host_running, command_byte,
                   input ready);
   modport sink (input valid, func, level_sample, host_running, command_byte,
                 output ready);
endinterface

interface bps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bps_pkg::LEVEL_W-1:0]  read_data;
   logic                         last_byte;
   logic                         power_enable;
   logic                         shutdown_request;
   logic [bps_pkg::LED_W-1:0]    led_code;

   modport source (output valid, read_data, last_byte, power_enable,
                   shutdown_request, led_code, input ready);
   modport sink (input valid, read_data, last_byte, power_enable,
                 shutdown_request, led_code, output ready);
endinterface

// ----- rtl/bps_csr.sv -----
// configuration registers behind the apb-style port
module bps_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bps_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [bps_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [bps_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output bps_pkg::cfg_type              cfg_o
);

   bps_pkg::cfg_type            cfg_ff;
   bps_pkg::cfg_type            cfg_in;
   logic [bps_pkg::REG_W-1:0]   reg_idx;
   logic                        wr_en;

   assign reg_idx    = csr_paddr[bps_pkg::ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg_o      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            bps_pkg::REG_STARTUP:   cfg_in.startup_level   = csr_pwdata[bps_pkg::LEVEL_W-1:0];
            bps_pkg::REG_SHUTDOWN:  cfg_in.shutdown_level  = csr_pwdata[bps_pkg::LEVEL_W-1:0];
            bps_pkg::REG_EMERG:     cfg_in.emergency_level = csr_pwdata[bps_pkg::LEVEL_W-1:0];
            bps_pkg::REG_WD_LIMIT:  cfg_in.watchdog_limit_ticks =
                                       csr_pwdata[bps_pkg::TICKS_W-1:0];
            bps_pkg::REG_BOOT_WAIT: cfg_in.boot_wait_ticks = csr_pwdata[bps_pkg::TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         bps_pkg::REG_STARTUP:   csr_prdata = 32'(cfg_ff.startup_level);
         bps_pkg::REG_SHUTDOWN:  csr_prdata = 32'(cfg_ff.shutdown_level);
         bps_pkg::REG_EMERG:     csr_prdata = 32'(cfg_ff.emergency_level);
         bps_pkg::REG_WD_LIMIT:  csr_prdata = 32'(cfg_ff.watchdog_limit_ticks);
         bps_pkg::REG_BOOT_WAIT: csr_prdata = 32'(cfg_ff.boot_wait_ticks);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_level        <= bps_pkg::RST_STARTUP;
         cfg_ff.shutdown_level       <= bps_pkg::RST_SHUTDOWN;
         cfg_ff.emergency_level      <= bps_pkg::RST_EMERG;
         cfg_ff.watchdog_limit_ticks <= bps_pkg::RST_WD_LIMIT;
         cfg_ff.boot_wait_ticks      <= bps_pkg::RST_BOOT_WAIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/bps_core.sv -----
// supervisor state and the one-pass update for one transaction
module bps_core #(
   parameter int STREAK_LIMIT         = 5,
   parameter int EMERGENCY_LIMIT      = 50,
   parameter int CYCLE_OFF_TICKS      = 10,
   parameter int WATCHDOG_OFF_TICKS   = 3,
   parameter int EMERGENCY_HOLD_TICKS = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_i,
   input  bps_pkg::item_type    item_i,
   input  bps_pkg::cfg_type     cfg_i,
   output bps_pkg::bundle_type  bundle_o
);

   localparam logic signed [bps_pkg::STREAK_W-1:0] STREAK_HI = 4'(STREAK_LIMIT);
   localparam logic signed [bps_pkg::STREAK_W-1:0] STREAK_LO = -STREAK_HI;
   localparam logic [bps_pkg::EMERG_W-1:0] EMERG_LIM  = 6'(EMERGENCY_LIMIT);
   localparam logic [bps_pkg::TICKS_W-1:0] CYCLE_OFF  = 16'(CYCLE_OFF_TICKS);
   localparam logic [bps_pkg::TICKS_W-1:0] WD_OFF     = 16'(WATCHDOG_OFF_TICKS);
   localparam logic [bps_pkg::TICKS_W-1:0] EMERG_HOLD = 16'(EMERGENCY_HOLD_TICKS);

   logic [bps_pkg::LEVEL_W-1:0]         last_level_ff, last_level_in;
   logic [bps_pkg::CMD_W-1:0]           read_select_ff, read_select_in;
   logic                                armed_ff, armed_in;
   logic [bps_pkg::TICKS_W-1:0]         wd_count_ff, wd_count_in;
   logic signed [bps_pkg::STREAK_W-1:0] streak_ff, streak_in;
   logic [bps_pkg::EMERG_W-1:0]         emerg_ff, emerg_in;
   logic                                power_ff, power_in;
   logic                                flag_ff, flag_in;
   logic                                blink_ff, blink_in;
   logic [bps_pkg::LED_W-1:0]           led_ff, led_in;
   logic [bps_pkg::TICKS_W-1:0]         wait_ff, wait_in;
   logic                                pend_on_ff, pend_on_in;
   logic                                pend_boot_ff, pend_boot_in;
   logic [bps_pkg::LEVEL_W-1:0]         lvl;

   assign lvl = item_i.level_sample;

   always_comb begin
      last_level_in  = last_level_ff;
      read_select_in = read_select_ff;
      armed_in       = armed_ff;
      wd_count_in    = wd_count_ff;
      streak_in      = streak_ff;
      emerg_in       = emerg_ff;
      power_in       = power_ff;
      flag_in        = flag_ff;
      blink_in       = blink_ff;
      led_in         = led_ff;
      wait_in        = wait_ff;
      pend_on_in     = pend_on_ff;
      pend_boot_in   = pend_boot_ff;
      bundle_o.count = '0;
      bundle_o.data  = '0;
      if (step_i) begin
         case (item_i.func)
            bps_pkg::FUNC_TICK: begin
               bundle_o.count = 2'd1;
               if (armed_ff && wd_count_ff != bps_pkg::WD_MAX) begin
                  wd_count_in = wd_count_ff + 16'd1;
               end
               if (wait_ff != '0) begin
                  // waiting: only count down, then finish pending actions
                  wait_in = wait_ff - 16'd1;
                  if (wait_in == '0) begin
                     if (pend_on_ff) begin
                        pend_on_in = 1'b0;
                        led_in     = bps_pkg::LED_GREEN;
                        power_in   = 1'b1;
                        flag_in    = 1'b0;
                     end
                     if (pend_boot_ff) begin
                        pend_boot_in = 1'b0;
                        wait_in      = cfg_i.boot_wait_ticks;
                     end
                  end
               end else begin
                  last_level_in = lvl;
                  if (armed_ff && wd_count_in > cfg_i.watchdog_limit_ticks) begin
                     // watchdog trip: power cycle the host
                     led_in       = bps_pkg::LED_YELLOW;
                     power_in     = 1'b0;
                     flag_in      = 1'b1;
                     wd_count_in  = '0;
                     pend_on_in   = 1'b1;
                     pend_boot_in = 1'b0;
                     wait_in      = WD_OFF;
                  end else if (lvl <= cfg_i.emergency_level) begin
                     if (emerg_ff != bps_pkg::EMERG_MAX) begin
                        emerg_in = emerg_ff + 6'd1;
                     end
                     if (emerg_in > EMERG_LIM) begin
                        led_in   = bps_pkg::LED_RED;
                        power_in = 1'b0;
                        flag_in  = 1'b1;
                        wait_in  = EMERG_HOLD;
                     end
                  end else if (lvl > cfg_i.startup_level) begin
                     emerg_in = '0;
                     if (streak_ff > STREAK_HI) begin
                        if (!power_ff) begin
                           led_in   = bps_pkg::LED_GREEN;
                           power_in = 1'b1;
                           flag_in  = 1'b0;
                           wait_in  = cfg_i.boot_wait_ticks;
                        end else if (!item_i.host_running) begin
                           led_in       = bps_pkg::LED_YELLOW;
                           power_in     = 1'b0;
                           flag_in      = 1'b1;
                           pend_on_in   = 1'b1;
                           pend_boot_in = 1'b1;
                           wait_in      = CYCLE_OFF;
                        end else begin
                           flag_in  = 1'b0;
                           blink_in = !blink_ff;
                           led_in   = blink_in ? bps_pkg::LED_GREEN : bps_pkg::LED_OFF;
                        end
                     end else begin
                        streak_in = (streak_ff < 4'sd0) ? 4'sd0 : streak_ff;
                        if (streak_in < bps_pkg::STREAK_MAX) begin
                           streak_in = streak_in + 4'sd1;
                        end
                     end
                  end else if (lvl <= cfg_i.shutdown_level) begin
                     emerg_in = '0;
                     if (streak_ff < STREAK_LO) begin
                        if (item_i.host_running) begin
                           flag_in  = 1'b1;
                           blink_in = !blink_ff;
                           led_in   = blink_in ? bps_pkg::LED_YELLOW : bps_pkg::LED_OFF;
                        end else if (power_ff) begin
                           power_in = 1'b0;
                           flag_in  = 1'b1;
                           led_in   = bps_pkg::LED_OFF;
                        end
                     end else begin
                        streak_in = (streak_ff > 4'sd0) ? 4'sd0 : streak_ff;
                        if (streak_in > bps_pkg::STREAK_MIN) begin
                           streak_in = streak_in - 4'sd1;
                        end
                     end
                  end
               end
            end
            bps_pkg::FUNC_CMD: begin
               if (item_i.command_byte inside {bps_pkg::SEL_LEVEL, bps_pkg::SEL_FLAG,
                                               [bps_pkg::SEL_ALL:bps_pkg::SEL_EMERG]}) begin
                  read_select_in = item_i.command_byte;
               end else if (item_i.command_byte == bps_pkg::CMD_ARM) begin
                  armed_in    = 1'b1;
                  wd_count_in = '0;
               end else if (item_i.command_byte == bps_pkg::CMD_DISARM) begin
                  armed_in    = 1'b0;
                  wd_count_in = '0;
               end
            end
            bps_pkg::FUNC_READ: begin
               if (armed_ff) begin
                  wd_count_in = '0;
               end
               case (read_select_ff)
                  bps_pkg::SEL_LEVEL: begin
                     bundle_o.count   = 2'd1;
                     bundle_o.data[0] = last_level_ff;
                  end
                  bps_pkg::SEL_FLAG: begin
                     bundle_o.count   = 2'd1;
                     bundle_o.data[0] = 8'(flag_ff);
                  end
                  bps_pkg::SEL_ALL: begin
                     bundle_o.count   = 2'd3;
                     bundle_o.data[0] = cfg_i.startup_level;
                     bundle_o.data[1] = cfg_i.shutdown_level;
                     bundle_o.data[2] = cfg_i.emergency_level;
                  end
                  bps_pkg::SEL_STARTUP: begin
                     bundle_o.count   = 2'd1;
                     bundle_o.data[0] = cfg_i.startup_level;
                  end
                  bps_pkg::SEL_SHUTDOWN: begin
                     bundle_o.count   = 2'd1;
                     bundle_o.data[0] = cfg_i.shutdown_level;
                  end
                  bps_pkg::SEL_EMERG: begin
                     bundle_o.count   = 2'd1;
                     bundle_o.data[0] = cfg_i.emergency_level;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      bundle_o.power_enable     = power_in;
      bundle_o.shutdown_request = flag_in;
      bundle_o.led_code         = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= '0;
         read_select_ff <= bps_pkg::SEL_NONE;
         armed_ff       <= 1'b0;
         wd_count_ff    <= '0;
         streak_ff      <= '0;
         emerg_ff       <= '0;
         power_ff       <= 1'b0;
         flag_ff        <= 1'b0;
         blink_ff       <= 1'b0;
         led_ff         <= bps_pkg::LED_OFF;
         wait_ff        <= '0;
         pend_on_ff     <= 1'b0;
         pend_boot_ff   <= 1'b0;
      end else begin
         last_level_ff  <= last_level_in;
         read_select_ff <= read_select_in;
         armed_ff       <= armed_in;
         wd_count_ff    <= wd_count_in;
         streak_ff      <= streak_in;
         emerg_ff       <= emerg_in;
         power_ff       <= power_in;
         flag_ff        <= flag_in;
         blink_ff       <= blink_in;
         led_ff         <= led_in;
         wait_ff        <= wait_in;
         pend_on_ff     <= pend_on_in;
         pend_boot_ff   <= pend_boot_in;
      end
   end

endmodule

// ----- rtl/bps_out.sv -----
// result register that hands out a transaction's results one per cycle while the receiver is ready
module bps_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_i,
   input  bps_pkg::bundle_type  bundle_i,
   output logic                 free_o,
   bps_rsp_if.source            rsp_ch
);

   logic                        valid_ff, valid_in;
   logic [bps_pkg::CNT_W-1:0]   idx_ff, idx_in;
   bps_pkg::bundle_type         bundle_ff, bundle_in;
   logic                        last;
   logic                        take;
   logic                        load;

   assign last   = (idx_ff == bundle_ff.count - 2'd1);
   assign take   = valid_ff & rsp_ch.ready;
   assign free_o = !valid_ff || (rsp_ch.ready && last);
   assign load   = step_i && (bundle_i.count != '0);

   assign rsp_ch.valid            = valid_ff;
   assign rsp_ch.read_data        = bundle_ff.data[idx_ff];
   assign rsp_ch.last_byte        = last;
   assign rsp_ch.power_enable     = bundle_ff.power_enable;
   assign rsp_ch.shutdown_request = bundle_ff.shutdown_request;
   assign rsp_ch.led_code         = bundle_ff.led_code;

   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      bundle_in = bundle_ff;
      if (take && !last) begin
         idx_in = idx_ff + 2'd1;
      end
      if (load) begin
         valid_in  = 1'b1;
         idx_in    = '0;
         bundle_in = bundle_i;
      end else if (take && last) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

endmodule

// ----- rtl/battery_power_supervisor.sv -----
// top level of the battery power supervisor
//
// req_ch carries one transaction per tick (level and host pin), bus command
// byte or bus read request. rsp_ch returns one result per tick, one per byte
// of the selected register on a read (three for the threshold block), none
// for a command. the csr_ port is an apb-style port holding the thresholds,
// the watchdog limit and the boot wait.
// a transaction is taken into an input register; when the result register
// is free, the core logic updates the supervisor state and loads the
// results into the result register. throughput is one transaction per
// cycle while the receiver takes results; a read of the threshold block
// holds the result register until all three of its bytes are taken.
// reset restores the register defaults and clears all supervisor state.
// when the receiver stalls, the result register holds; one more transaction
// waits in the input register and then req_ch.ready drops.
module battery_power_supervisor #(
   parameter int STREAK_LIMIT         = 5,
   parameter int EMERGENCY_LIMIT      = 50,
   parameter int CYCLE_OFF_TICKS      = 10,
   parameter int WATCHDOG_OFF_TICKS   = 3,
   parameter int EMERGENCY_HOLD_TICKS = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   bps_req_if.sink                       req_ch,
   bps_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bps_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [bps_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [bps_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   bps_pkg::cfg_type     cfg;
   bps_pkg::bundle_type  bundle;
   bps_pkg::item_type    item_ff, item_in;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_free;
   logic                 step;
   logic                 req_take;

   // input register advances when the result register can take its results
   assign step         = in_valid_ff & out_free;
   assign req_ch.ready = !in_valid_ff || step;
   assign req_take     = req_ch.valid & req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_take) begin
         in_valid_in          = 1'b1;
         item_in.func         = req_ch.func;
         item_in.level_sample = req_ch.level_sample;
         item_in.host_running = req_ch.host_running;
         item_in.command_byte = req_ch.command_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   bps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_o       (cfg)
   );

   bps_core #(
      .STREAK_LIMIT         (STREAK_LIMIT),
      .EMERGENCY_LIMIT      (EMERGENCY_LIMIT),
      .CYCLE_OFF_TICKS      (CYCLE_OFF_TICKS),
      .WATCHDOG_OFF_TICKS   (WATCHDOG_OFF_TICKS),
      .EMERGENCY_HOLD_TICKS (EMERGENCY_HOLD_TICKS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_i   (step),
      .item_i   (item_ff),
      .cfg_i    (cfg),
      .bundle_o (bundle)
   );

   bps_out u_out (
      .clock    (clock),
      .reset    (reset),
      .step_i   (step),
      .bundle_i (bundle),
      .free_o   (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- sim/battery_power_supervisor_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the battery power supervisor with a reply mirror class
module battery_power_supervisor_tb;
   import bps_pkg::*;

   // block parameters, kept at the values the dut is built with
   localparam int STREAK_LIMIT         = 5;
   localparam int EMERGENCY_LIMIT      = 50;
   localparam int CYCLE_OFF_TICKS      = 10;
   localparam int WATCHDOG_OFF_TICKS   = 3;
   localparam int EMERGENCY_HOLD_TICKS = 9;

   localparam int MAX_SHOWN = 10;

   // function code and command byte that the block must ignore
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [CMD_W-1:0]  CMD_JUNK    = 8'hFF;

   // level bands relative to the current thresholds
   typedef enum int {BAND_HIGH, BAND_MID, BAND_LOW, BAND_EMERG} band_type;

   // one result transaction as seen on rsp_ch
   typedef struct packed {
      logic [LEVEL_W-1:0] read_data;
      logic               last_byte;
      logic               power_enable;
      logic               shutdown_request;
      logic [LED_W-1:0]   led_code;
   } reply_type;

   // mirror of the supervisor: tracks its state, queues the replies it owes
   class supervisor_mirror;
      cfg_type            cfg;
      logic [LEVEL_W-1:0] last_level;
      logic [CMD_W-1:0]   read_select;
      bit                 armed;
      logic [TICKS_W-1:0] wd_count;
      logic [TICKS_W-1:0] wait_count;
      int                 streak;
      logic [EMERG_W-1:0] emerg_count;
      bit                 power_on;
      bit                 shutdown_flag;
      bit                 blink_phase;
      bit                 pending_on;
      bit                 pending_boot;
      logic [LED_W-1:0]   led;
      reply_type          replies_due[$];
      int                 mismatches;
      int                 replies_seen;
      int                 requests_seen;

      function new();
         cfg = cfg_type'{RST_STARTUP, RST_SHUTDOWN, RST_EMERG, RST_WD_LIMIT, RST_BOOT_WAIT};
         last_level    = '0;
         read_select   = SEL_NONE;
         armed         = 1'b0;
         wd_count      = '0;
         wait_count    = '0;
         streak        = 0;
         emerg_count   = '0;
         power_on      = 1'b0;
         shutdown_flag = 1'b0;
         blink_phase   = 1'b0;
         pending_on    = 1'b0;
         pending_boot  = 1'b0;
         led           = LED_OFF;
         mismatches    = 0;
         replies_seen  = 0;
         requests_seen = 0;
      endfunction

      function void store_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_STARTUP:   cfg.startup_level        = value[LEVEL_W-1:0];
            REG_SHUTDOWN:  cfg.shutdown_level       = value[LEVEL_W-1:0];
            REG_EMERG:     cfg.emergency_level      = value[LEVEL_W-1:0];
            REG_WD_LIMIT:  cfg.watchdog_limit_ticks = value[TICKS_W-1:0];
            REG_BOOT_WAIT: cfg.boot_wait_ticks      = value[TICKS_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_fail(string what);
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("mismatch: %s", what);
      endfunction

      function string show(reply_type r);
         return $sformatf("data %0d last %0d pwr %0d shut %0d led %0d", r.read_data,
                          r.last_byte, r.power_enable, r.shutdown_request, r.led_code);
      endfunction

      function void emit(logic [LEVEL_W-1:0] data, bit last);
         replies_due.push_back(reply_type'{data, last, power_on, shutdown_flag, led});
      endfunction

      function void cut_supply();
         power_on      = 1'b0;
         shutdown_flag = 1'b1;
      endfunction

      function void raise_supply();
         power_on      = 1'b1;
         shutdown_flag = 1'b0;
      endfunction

      function void blink(logic [LED_W-1:0] color);
         blink_phase = !blink_phase;
         led         = blink_phase ? color : LED_OFF;
      endfunction

      // a tick that is not swallowed by a pending wait
      function void active_tick(logic [LEVEL_W-1:0] lvl, bit host);
         last_level = lvl;
         if (armed && wd_count > cfg.watchdog_limit_ticks) begin
            led = LED_YELLOW;
            cut_supply();
            wd_count     = '0;
            pending_on   = 1'b1;
            pending_boot = 1'b0;
            wait_count   = 16'(WATCHDOG_OFF_TICKS);
            return;
         end
         if (lvl <= cfg.emergency_level) begin
            if (emerg_count != EMERG_MAX)
               emerg_count++;
            if (emerg_count > EMERGENCY_LIMIT) begin
               led = LED_RED;
               cut_supply();
               wait_count = 16'(EMERGENCY_HOLD_TICKS);
            end
         end else if (lvl > cfg.startup_level) begin
            emerg_count = '0;
            if (streak > STREAK_LIMIT) begin
               if (!power_on) begin
                  led = LED_GREEN;
                  raise_supply();
                  wait_count = cfg.boot_wait_ticks;
               end else if (!host) begin
                  led = LED_YELLOW;
                  cut_supply();
                  pending_on   = 1'b1;
                  pending_boot = 1'b1;
                  wait_count   = 16'(CYCLE_OFF_TICKS);
               end else begin
                  shutdown_flag = 1'b0;
                  blink(LED_GREEN);
               end
            end else begin
               if (streak < 0)
                  streak = 0;
               if (streak < 7)
                  streak++;
            end
         end else if (lvl <= cfg.shutdown_level) begin
            emerg_count = '0;
            if (streak < -STREAK_LIMIT) begin
               if (host) begin
                  shutdown_flag = 1'b1;
                  blink(LED_YELLOW);
               end else if (power_on) begin
                  cut_supply();
                  led = LED_OFF;
               end
            end else begin
               if (streak > 0)
                  streak = 0;
               if (streak > -8)
                  streak--;
            end
         end
      endfunction

      function void take_request(item_type it);
         requests_seen++;
         case (it.func)
            FUNC_TICK: begin
               if (armed && wd_count != WD_MAX)
                  wd_count++;
               if (wait_count != 0) begin
                  wait_count--;
                  if (wait_count == 0) begin
                     if (pending_on) begin
                        pending_on = 1'b0;
                        led = LED_GREEN;
                        raise_supply();
                     end
                     if (pending_boot) begin
                        pending_boot = 1'b0;
                        wait_count   = cfg.boot_wait_ticks;
                     end
                  end
               end else begin
                  active_tick(it.level_sample, it.host_running);
               end
               emit('0, 1'b1);
            end
            FUNC_CMD: begin
               case (it.command_byte)
                  SEL_LEVEL, SEL_FLAG, SEL_ALL, SEL_STARTUP, SEL_SHUTDOWN, SEL_EMERG:
                     read_select = it.command_byte;
                  CMD_ARM: begin
                     armed    = 1'b1;
                     wd_count = '0;
                  end
                  CMD_DISARM: begin
                     armed    = 1'b0;
                     wd_count = '0;
                  end
                  default: ;
               endcase
            end
            FUNC_READ: begin
               if (armed)
                  wd_count = '0;
               case (read_select)
                  SEL_LEVEL:    emit(last_level, 1'b1);
                  SEL_FLAG:     emit({{(LEVEL_W-1){1'b0}}, shutdown_flag}, 1'b1);
                  SEL_ALL: begin
                     emit(cfg.startup_level, 1'b0);
                     emit(cfg.shutdown_level, 1'b0);
                     emit(cfg.emergency_level, 1'b1);
                  end
                  SEL_STARTUP:  emit(cfg.startup_level, 1'b1);
                  SEL_SHUTDOWN: emit(cfg.shutdown_level, 1'b1);
                  SEL_EMERG:    emit(cfg.emergency_level, 1'b1);
                  default: ;
               endcase
            end
            default: ;
         endcase
      endfunction

      function void match_reply(reply_type got);
         reply_type want;
         replies_seen++;
         if (replies_due.size() == 0) begin
            note_fail({"reply with none outstanding: ", show(got)});
            return;
         end
         want = replies_due.pop_front();
         if (got.read_data !== want.read_data || got.last_byte !== want.last_byte ||
             got.power_enable !== want.power_enable ||
             got.shutdown_request !== want.shutdown_request ||
             got.led_code !== want.led_code)
            note_fail({"expected ", show(want), ", got ", show(got)});
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [ADDR_W-1:0]  csr_paddr;
   logic [DATA_W-1:0]  csr_pwdata;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   // idle odds, in percent, of the request sender and the reply receiver
   int req_idle_pct;
   int rsp_idle_pct;

   bps_req_if req_ch();
   bps_rsp_if rsp_ch();

   supervisor_mirror mirror = new();

   battery_power_supervisor dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // reply side: check every accepted transaction, then pick the next ready
   always @(posedge clock) begin
      reply_type seen;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen = reply_type'{rsp_ch.read_data, rsp_ch.last_byte, rsp_ch.power_enable,
                            rsp_ch.shutdown_request, rsp_ch.led_code};
         mirror.match_reply(seen);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // random filler for payload fields the block ignores
   function automatic logic [LEVEL_W-1:0] any_byte();
      return LEVEL_W'($urandom);
   endfunction

   function automatic logic any_bit();
      return 1'($urandom);
   endfunction

   // send one request transaction, with random idle cycles ahead of it
   task automatic issue(logic [FUNC_W-1:0] f, logic [LEVEL_W-1:0] lvl, logic host,
                        logic [CMD_W-1:0] cmd);
      item_type it;
      it = item_type'{f, lvl, host, cmd};
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= f;
      req_ch.level_sample <= lvl;
      req_ch.host_running <= host;
      req_ch.command_byte <= cmd;
      // ready is read before this edge's updates land, so it is what the dut saw
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      mirror.take_request(it);
   endtask

   // stop sending and let every owed reply come back, plus the pipeline depth
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (mirror.replies_due.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // one apb transfer: setup cycle, then access until pready
   task automatic csr_access(bit wr, logic [REG_W-1:0] idx, logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // then stay quiet so back to back transfers never touch psel twice in a step
      @(posedge clock);
   endtask

   // write a register, tell the mirror, and read it back
   task automatic write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] back;
      csr_access(1'b1, idx, value, back);
      mirror.store_reg(idx, value);
      csr_access(1'b0, idx, '0, back);
      if (back !== value)
         mirror.note_fail($sformatf("register %0d reads %0h after writing %0h",
                                    idx, back, value));
   endtask

   task automatic load_setting(cfg_type c);
      write_reg(REG_STARTUP, DATA_W'(c.startup_level));
      write_reg(REG_SHUTDOWN, DATA_W'(c.shutdown_level));
      write_reg(REG_EMERG, DATA_W'(c.emergency_level));
      write_reg(REG_WD_LIMIT, DATA_W'(c.watchdog_limit_ticks));
      write_reg(REG_BOOT_WAIT, DATA_W'(c.boot_wait_ticks));
   endtask

   // a level inside the band under the current thresholds, any level if empty
   function automatic logic [LEVEL_W-1:0] level_in(band_type band);
      int lo;
      int hi;
      case (band)
         BAND_HIGH: begin
            lo = int'(mirror.cfg.startup_level) + 1;
            hi = 255;
         end
         BAND_MID: begin
            lo = int'(mirror.cfg.shutdown_level) + 1;
            hi = int'(mirror.cfg.startup_level);
         end
         BAND_LOW: begin
            lo = int'(mirror.cfg.emergency_level) + 1;
            hi = int'(mirror.cfg.shutdown_level);
         end
         default: begin
            lo = 0;
            hi = int'(mirror.cfg.emergency_level);
         end
      endcase
      if (lo > hi)
         return LEVEL_W'($urandom_range(0, 255));
      return LEVEL_W'($urandom_range(lo, hi));
   endfunction

   // mostly runs of ticks in one band (builds streaks and emergency counts),
   // mixed with bus commands, reads and some ignored noise
   task automatic random_traffic(int target);
      int               done;
      int               pick;
      int               run;
      band_type         band;
      bit               host;
      bit               steady;
      logic [CMD_W-1:0] cmd;
      done = 0;
      while (done < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            case ($urandom_range(0, 9))
               0, 1, 2: cmd = CMD_ARM;
               3:       cmd = CMD_DISARM;
               4:       cmd = SEL_LEVEL;
               5:       cmd = SEL_FLAG;
               6:       cmd = SEL_ALL;
               7:       cmd = SEL_STARTUP;
               8:       cmd = SEL_SHUTDOWN;
               default: cmd = SEL_EMERG;
            endcase
            issue(FUNC_CMD, any_byte(), any_bit(), cmd);
            done++;
         end else if (pick < 20) begin
            issue(FUNC_READ, any_byte(), any_bit(), any_byte());
            done++;
         end else if (pick < 23) begin
            // noise: unused function code or an arbitrary command byte
            if (pick == 20)
               issue(FUNC_UNUSED, any_byte(), any_bit(), any_byte());
            else
               issue(FUNC_CMD, any_byte(), any_bit(), any_byte());
         end else begin
            band = band_type'($urandom_range(0, 3));
            // now and then an emergency run long enough to reach the cutoff
            if (band == BAND_EMERG && $urandom_range(0, 3) == 0)
               run = $urandom_range(52, 60);
            else
               run = $urandom_range(1, 12);
            steady = ($urandom_range(0, 4) != 0);
            host   = any_bit();
            repeat (run) begin
               issue(FUNC_TICK, level_in(band), steady ? host : any_bit(), any_byte());
               done++;
            end
         end
      end
   endtask

   initial begin
      cfg_type plan [6];
      int      phase;

      // threshold settings, from ordinary to extreme; short limits and waits
      // keep watchdog trips and boot waits frequent
      plan[0] = cfg_type'{8'd150, 8'd100, 8'd50, 16'd8, 16'd4};
      plan[1] = cfg_type'{8'd255, 8'd0, 8'd0, 16'd1, 16'd0};
      plan[2] = cfg_type'{8'd0, 8'd255, 8'd128, 16'd12, 16'd2};
      plan[3] = cfg_type'{8'd200, 8'd120, 8'd60, 16'd30, 16'd7};
      plan[4] = cfg_type'{RST_STARTUP, RST_SHUTDOWN, RST_EMERG, 16'd40, 16'd3};
      plan[5] = cfg_type'{8'd180, 8'd90, 8'd40, 16'hFFFF, 16'hFFFF};

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_TICK;
      req_ch.level_sample = '0;
      req_ch.host_running = 1'b0;
      req_ch.command_byte = '0;
      rsp_ch.ready        = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_idle_pct        = 27;
      rsp_idle_pct        = 88;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset thresholds
      // read with nothing selected owes no reply
      issue(FUNC_READ, 8'h00, 1'b0, 8'h00);
      // ignored function code and command bytes
      issue(FUNC_UNUSED, 8'hFF, 1'b1, 8'hFF);
      issue(FUNC_CMD, 8'hFF, 1'b1, SEL_NONE);
      issue(FUNC_CMD, 8'h00, 1'b0, CMD_JUNK);
      // every read register, the threshold block gives three bytes
      issue(FUNC_CMD, any_byte(), any_bit(), SEL_ALL);
      issue(FUNC_READ, any_byte(), any_bit(), any_byte());
      issue(FUNC_CMD, any_byte(), any_bit(), SEL_STARTUP);
      issue(FUNC_READ, any_byte(), any_bit(), any_byte());
      issue(FUNC_CMD, any_byte(), any_bit(), SEL_SHUTDOWN);
      issue(FUNC_READ, any_byte(), any_bit(), any_byte());
      issue(FUNC_CMD, any_byte(), any_bit(), SEL_EMERG);
      issue(FUNC_READ, any_byte(), any_bit(), any_byte());
      // level extremes and each band edge
      issue(FUNC_TICK, 8'hFF, 1'b1, 8'h00);
      issue(FUNC_TICK, 8'h00, 1'b0, 8'hFF);
      issue(FUNC_TICK, RST_STARTUP, 1'b1, any_byte());
      issue(FUNC_TICK, RST_SHUTDOWN + 8'd1, 1'b0, any_byte());
      issue(FUNC_TICK, RST_SHUTDOWN, 1'b1, any_byte());
      issue(FUNC_TICK, RST_EMERG, 1'b0, any_byte());
      issue(FUNC_CMD, any_byte(), any_bit(), SEL_LEVEL);
      issue(FUNC_READ, any_byte(), any_bit(), any_byte());
      issue(FUNC_CMD, any_byte(), any_bit(), SEL_FLAG);
      issue(FUNC_READ, any_byte(), any_bit(), any_byte());
      // arm, a tick, a read that restarts the count, disarm
      issue(FUNC_CMD, any_byte(), any_bit(), CMD_ARM);
      issue(FUNC_TICK, RST_EMERG + 8'd1, 1'b1, any_byte());
      issue(FUNC_READ, any_byte(), any_bit(), any_byte());
      issue(FUNC_CMD, any_byte(), any_bit(), CMD_DISARM);
      drain();

      // random part, one batch per setting; idle odds swap at the third batch and drop to zero for the fifth
      for (phase = 0; phase < 5; phase++) begin
         if (phase == 2) begin
            req_idle_pct = 88;
            rsp_idle_pct = 27;
         end else if (phase == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         load_setting(plan[phase]);
         random_traffic(45);
         drain();
      end

      // longest limit and boot wait: force a cutoff, then a power up that
      // starts the full boot wait, and tick an armed watchdog through it
      load_setting(plan[5]);
      repeat (60) issue(FUNC_TICK, 8'h00, any_bit(), any_byte());
      repeat (20) issue(FUNC_TICK, 8'hFF, 1'b1, any_byte());
      issue(FUNC_CMD, any_byte(), any_bit(), CMD_ARM);
      repeat (12) issue(FUNC_TICK, any_byte(), any_bit(), any_byte());
      issue(FUNC_CMD, any_byte(), any_bit(), SEL_LEVEL);
      issue(FUNC_READ, any_byte(), any_bit(), any_byte());
      drain();

      $display("run covered %0d requests and %0d replies", mirror.requests_seen,
               mirror.replies_seen);
      $display("over the reset thresholds and %0d settings, %0d mismatches", 6,
               mirror.mismatches);
      if (mirror.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
